>>> src/sdi_pkg.sv
//------------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants for the smallest-denominator interval core.
//------------------------------------------------------------------------------
package sdi_pkg;

    localparam int PATH_DEPTH = 64;
    localparam int AW = $clog2(PATH_DEPTH);
    localparam int LW = $clog2(PATH_DEPTH + 1);
    localparam logic [30:0] RUN_INF = 31'h7fffffff;
    localparam logic [30:0] SAT31 = 31'h7fffffff;
    localparam logic [3:0] MAX_DIGITS = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SETUP,
        ST_DIV,
        ST_STORE,
        ST_EXT,
        ST_EXT_WR,
        ST_WALK_RD,
        ST_WALK_MUL,
        ST_WALK_ACC,
        ST_DONE
    } state_t;

endpackage

>>> src/smallest_denominator_in_interval_core.sv
//------------------------------------------------------------------------------
// smallest_denominator_in_interval_core
// Finds the smallest denominator of a fraction inside a decimal rounding
// interval by expanding both bounds into run-length paths and walking them.
//------------------------------------------------------------------------------
// Channel  Dir  Contents
// s_axis   in   tdata[29:0] frac_value, tdata[33:30] digit_count, tdata[34] is_one
// m_axis   out  tdata[30:0] denominator
//
// One item is processed at a time. Each run of each bound expansion uses one
// 32-step restoring divider, and each prefix run of the walk passes through the
// read, multiply and accumulate states. Each path memory takes one write and one
// registered read per cycle. Reset is synchronous; the result waits in the
// output register until it is taken.
//------------------------------------------------------------------------------
module smallest_denominator_in_interval_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // frac_value, digit_count, is_one
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // denominator
);
    import sdi_pkg::*;

    state_t state_reg, state_next;

    logic [30:0] lmem [PATH_DEPTH];
    logic [30:0] umem [PATH_DEPTH];
    logic [30:0] lrd_reg, urd_reg;

    logic [29:0] v_reg;
    logic [3:0]  p_reg;
    logic [30:0] base_reg;
    logic        ub_reg;       // 0: lower bound, 1: upper bound
    logic [31:0] m_reg, n_reg;
    logic        right_reg;
    logic [LW-1:0] len_reg, llen_reg, ulen_reg;
    logic [31:0] dvd_reg, dvs_reg, quo_reg, rem_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] lft_reg, rgt_reg, prod_reg;
    logic        diff_reg;
    logic [30:0] res_reg;
    logic        ovalid_reg;

    logic [31:0] rem_sh;
    logic        wr_en;
    logic        wr_upper;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [30:0] wr_data;
    logic [LW-1:0] min_len;
    logic [63:0] tot;

    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {1'b0, res_reg};
    assign min_len = (llen_reg < ulen_reg) ? llen_reg : ulen_reg;
    assign rem_sh = {rem_reg[30:0], dvd_reg[31]};
    assign tot = lft_reg + rgt_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (s_axis_tdata[34] || s_axis_tdata[29:0] == 30'd0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                if (p_reg == 4'd0) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                if (m_reg == n_reg || len_reg == LW'(PATH_DEPTH - 2)) begin
                    state_next = ub_reg ? ST_EXT : ST_SETUP;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == 6'd0) state_next = ST_STORE;
            end
            ST_STORE: state_next = ST_SETUP;
            ST_EXT: state_next = ST_EXT_WR;
            ST_EXT_WR: state_next = ST_WALK_RD;
            ST_WALK_RD: begin
                state_next = (len_reg >= min_len) ? ST_DONE : ST_WALK_MUL;
            end
            ST_WALK_MUL: state_next = ST_WALK_ACC;
            ST_WALK_ACC: state_next = diff_reg ? ST_DONE : ST_WALK_RD;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        wr_en = 1'b0;
        wr_upper = ub_reg;
        wr_addr = len_reg[AW-1:0];
        wr_data = quo_reg[30:0];
        rd_addr = len_reg[AW-1:0];
        case (state_reg)
            ST_SETUP: rd_addr = len_reg[AW-1:0] - AW'(1);
            ST_STORE: wr_en = 1'b1;
            ST_EXT: begin
                wr_en = 1'b1;
                wr_upper = 1'b1;
                if (len_reg[0]) begin
                    wr_addr = len_reg[AW-1:0] - AW'(1);
                    wr_data = (urd_reg + 31'd1) & SAT31;
                end else begin
                    wr_data = 31'd1;
                end
            end
            ST_EXT_WR: begin
                wr_en = 1'b1;
                wr_upper = 1'b1;
                wr_data = RUN_INF;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_upper) lmem[wr_addr] <= wr_data;
        if (wr_en && wr_upper) umem[wr_addr] <= wr_data;
        lrd_reg <= lmem[rd_addr];
        urd_reg <= umem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            llen_reg   <= '0;
            ulen_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (ovalid_reg && m_axis_tready) ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        v_reg    <= s_axis_tdata[29:0];
                        p_reg    <= (s_axis_tdata[33:30] == 4'd0) ? 4'd1 :
                                    (s_axis_tdata[33:30] > MAX_DIGITS) ? MAX_DIGITS :
                                    s_axis_tdata[33:30];
                        base_reg <= 31'd1;
                        res_reg  <= 31'd1;
                        ub_reg   <= 1'b0;
                    end
                end
                ST_SCALE: begin
                    if (p_reg != 4'd0) begin
                        base_reg <= base_reg * 31'd10;
                        p_reg <= p_reg - 4'd1;
                    end else begin
                        if ({1'b0, v_reg} >= base_reg) v_reg <= 30'(base_reg - 31'd1);
                        m_reg <= {1'b0, ({1'b0, ((v_reg >= 30'(base_reg)) ?
                                 30'(base_reg - 31'd1) : v_reg)} << 1) - 31'd1};
                        n_reg <= {base_reg, 1'b0};
                        len_reg <= '0;
                        right_reg <= 1'b0;
                    end
                end
                ST_SETUP: begin
                    if (m_reg == n_reg || len_reg == LW'(PATH_DEPTH - 2)) begin
                        if (!ub_reg) begin
                            llen_reg <= len_reg;
                            ub_reg <= 1'b1;
                            m_reg <= {1'b0, {1'b0, v_reg} << 1} + 32'd1;
                            n_reg <= {base_reg, 1'b0};
                            len_reg <= '0;
                            right_reg <= 1'b0;
                        end
                    end else begin
                        dvd_reg <= right_reg ? m_reg - 32'd1 : n_reg - 32'd1;
                        dvs_reg <= right_reg ? n_reg : m_reg;
                        quo_reg <= '0;
                        rem_reg <= '0;
                        cnt_reg <= 6'd32;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg != 6'd0) begin
                        dvd_reg <= dvd_reg << 1;
                        if (rem_sh >= dvs_reg) begin
                            rem_reg <= rem_sh - dvs_reg;
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                ST_STORE: begin
                    // (x-1) mod d + 1 is the residue kept by the subtraction.
                    if (right_reg) m_reg <= rem_reg + 32'd1;
                    else n_reg <= rem_reg + 32'd1;
                    right_reg <= !right_reg;
                    len_reg <= len_reg + LW'(1);
                end
                ST_EXT: begin
                    if (!len_reg[0]) len_reg <= len_reg + LW'(1);
                end
                ST_EXT_WR: begin
                    ulen_reg <= len_reg + LW'(1);
                    len_reg <= '0;
                    lft_reg <= 64'd1;
                    rgt_reg <= 64'd0;
                    right_reg <= 1'b0;
                end
                ST_WALK_RD: begin
                    if (len_reg >= min_len) begin
                        res_reg <= (tot > {33'd0, SAT31}) ? SAT31 : tot[30:0];
                    end
                end
                ST_WALK_MUL: begin
                    diff_reg <= lrd_reg != urd_reg;
                    prod_reg <= right_reg ? rgt_reg[31:0] *
                                {1'b0, ((lrd_reg < urd_reg) ? lrd_reg : urd_reg)}
                              : lft_reg[31:0] *
                                {1'b0, ((lrd_reg < urd_reg) ? lrd_reg : urd_reg)};
                end
                ST_WALK_ACC: begin
                    if (right_reg) begin
                        lft_reg <= (lft_reg + prod_reg > {33'd0, SAT31}) ?
                                   {33'd0, SAT31} : lft_reg + prod_reg;
                    end else begin
                        rgt_reg <= (rgt_reg + prod_reg > {33'd0, SAT31}) ?
                                   {33'd0, SAT31} : rgt_reg + prod_reg;
                    end
                    right_reg <= !right_reg;
                    len_reg <= len_reg + LW'(1);
                    if (diff_reg) begin
                        res_reg <= (tot + prod_reg > {33'd0, SAT31}) ? SAT31 :
                                   31'(tot + prod_reg);
                    end
                end
                ST_DONE: ovalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("tready while a result waits");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |=> m_axis_tvalid)
        else $error("result not presented");
    a_res_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata != 32'd0)
        else $error("zero denominator");

endmodule

>>> tb/testbench.sv
//------------------------------------------------------------------------------
// Testbench for smallest_denominator_in_interval_core
// Drives decimal fractions into the core, predicts the smallest denominator in
// each rounding interval with a path-walking model, and checks every result beat.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic       is_one;
        logic [3:0] digit_count;
        logic [29:0] frac_value;
    } frac_item_t;

    localparam int CYCLE_LIMIT = 20000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    frac_item_t  pending_items[$];
    logic [30:0] expected_dens[$];
    int          error_count = 0;
    int          dens_seen = 0;
    int          cycle_count = 0;
    bit          calm_phase = 1'b0;
    bit          hold_sender = 1'b0;

    smallest_denominator_in_interval_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic int expand_runs(longint unsigned m, longint unsigned n,
                                       ref longint unsigned runs[64]);
        int cnt;
        bit go_right;
        longint unsigned s;
        cnt = 0;
        go_right = 1'b0;
        while (m != n && cnt < sdi_pkg::PATH_DEPTH - 2) begin
            if (!go_right) begin
                s = (n - 1) / m;
                n = n - s * m;
            end else begin
                s = (m - 1) / n;
                m = m - s * n;
            end
            runs[cnt] = s & 64'h7fffffff;
            cnt++;
            go_right = !go_right;
        end
        return cnt;
    endfunction

    function automatic longint unsigned clip31(longint unsigned x);
        return (x > 64'h7fffffff) ? 64'h7fffffff : x;
    endfunction

    function automatic logic [30:0] smallest_den(frac_item_t it);
        longint unsigned lo_runs[64];
        longint unsigned hi_runs[64];
        longint unsigned v, scale, lft, rgt, s;
        int lo_len, hi_len, n, p;
        bit go_right;
        if (it.is_one || it.frac_value == 0) return 31'd1;
        p = it.digit_count;
        if (p < 1) p = 1;
        if (p > sdi_pkg::MAX_DIGITS) p = sdi_pkg::MAX_DIGITS;
        scale = 1;
        for (int k = 0; k < p; k++) scale = scale * 10;
        v = it.frac_value;
        if (v >= scale) v = scale - 1;
        lo_len = expand_runs(2 * v - 1, 2 * scale, lo_runs);
        hi_len = expand_runs(2 * v + 1, 2 * scale, hi_runs);
        if (hi_len % 2 == 1) begin
            hi_runs[hi_len - 1] = (hi_runs[hi_len - 1] + 1) & 64'h7fffffff;
        end else begin
            hi_runs[hi_len] = 1;
            hi_len++;
        end
        hi_runs[hi_len] = sdi_pkg::RUN_INF;
        hi_len++;
        lft = 1;
        rgt = 0;
        go_right = 1'b0;
        n = (lo_len < hi_len) ? lo_len : hi_len;
        for (int i = 0; i < n; i++) begin
            s = (lo_runs[i] < hi_runs[i]) ? lo_runs[i] : hi_runs[i];
            if (!go_right) rgt = clip31(rgt + lft * s);
            else lft = clip31(lft + rgt * s);
            if (lo_runs[i] != hi_runs[i]) break;
            go_right = !go_right;
        end
        return 31'(clip31(lft + rgt));
    endfunction

    function automatic frac_item_t make_item(int v, int p, bit one);
        frac_item_t it;
        it.frac_value = 30'(v);
        it.digit_count = 4'(p);
        it.is_one = one;
        return it;
    endfunction

    function automatic frac_item_t random_item();
        frac_item_t it;
        int p;
        longint unsigned scale;
        p = $urandom_range(1, 9);
        scale = 1;
        for (int k = 0; k < p; k++) scale = scale * 10;
        it.digit_count = 4'(p);
        it.is_one = ($urandom_range(0, 49) == 0);
        it.frac_value = 30'($urandom_range(0, int'(scale - 1)));
        case ($urandom_range(0, 9))
            0: it.frac_value = 30'($urandom);
            1: it.digit_count = 4'($urandom);
            default: ;
        endcase
        return it;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                expected_dens.push_back(smallest_den(frac_item_t'(s_axis_tdata[34:0])));
            end
            if (pending_items.size() > 0 && !hold_sender
                    && (calm_phase || $urandom_range(0, 99) >= 14)) begin
                s_axis_tdata <= {5'd0, pending_items.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        logic [30:0] want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            dens_seen <= dens_seen + 1;
            if (expected_dens.size() == 0) begin
                $error("unexpected beat: denominator %0d", m_axis_tdata[30:0]);
                error_count++;
            end else begin
                want = expected_dens.pop_front();
                if (m_axis_tdata[30:0] !== want) begin
                    $error("denominator: expected %0d, actual %0d", want,
                           m_axis_tdata[30:0]);
                    error_count++;
                end
            end
        end
        m_axis_tready <= calm_phase || ($urandom_range(0, 99) >= 14);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        for (int p = 1; p <= 9; p++) pending_items.push_back(make_item(1, p, 1'b0));
        pending_items.push_back(make_item(0, 3, 1'b0));
        pending_items.push_back(make_item(0, 0, 1'b1));
        pending_items.push_back(make_item(30'h3fffffff, 15, 1'b1));
        pending_items.push_back(make_item(999999999, 9, 1'b0));
        pending_items.push_back(make_item(9, 1, 1'b0));
        pending_items.push_back(make_item(5, 0, 1'b0));
        pending_items.push_back(make_item(123456789, 15, 1'b0));
        pending_items.push_back(make_item(30'h3fffffff, 9, 1'b0));
        pending_items.push_back(make_item(1000, 2, 1'b0));
        pending_items.push_back(make_item(333, 3, 1'b0));
        pending_items.push_back(make_item(142857, 6, 1'b0));
        pending_items.push_back(make_item(500000000, 9, 1'b0));
        pending_items.push_back(make_item(1, 9, 1'b1));
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge aclk);
        wait (!s_axis_tvalid && expected_dens.size() == 0);
        hold_sender = 1'b1;
        for (int i = 0; i < 150; i++) pending_items.push_back(random_item());
        repeat (10) @(posedge aclk);
        hold_sender = 1'b0;
        wait (pending_items.size() == 0);
        calm_phase = 1'b1;
        for (int i = 0; i < 100; i++) pending_items.push_back(random_item());
        wait (pending_items.size() == 0);
        calm_phase = 1'b0;
        for (int i = 0; i < 150; i++) pending_items.push_back(random_item());
        wait (pending_items.size() == 0);
        @(posedge aclk);
        wait (!s_axis_tvalid && expected_dens.size() == 0);
        repeat (50) @(posedge aclk);
        $display("Checked %0d denominators over all digit counts, exact zero and one,", dens_seen);
        $display("out-of-range digit counts and values, with random stalls on both sides.");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> smallest_denominator_in_interval_core.f
src/sdi_pkg.sv
src/smallest_denominator_in_interval_core.sv
tb/testbench.sv
